// File: design/prc_pkg.sv
// ----------------------------------------------------------------------------
// Pedal range calibrator package
// Shared types, step codes, register indexes and constants for the
// pedal range calibrator and its window scan unit.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Sample and register widths.
  localparam int DATA_W   = 12;
  localparam int TICKS_W  = 8;
  localparam int STEP_W   = 3;
  localparam int CFG_IDX_W = 2;

  // Default window length and register reset values.
  localparam int WINDOW_LEN_DEF = 20;
  localparam logic [DATA_W-1:0]  THRESHOLD_RST = 12'd30;
  localparam logic [TICKS_W-1:0] TICKS_RST     = 8'd20;
  localparam logic [DATA_W-1:0]  MIN_SWING_RST = 12'd100;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWING = 2'd2;

  // Step codes.
  localparam logic [STEP_W-1:0] STEP_HEEL1 = 3'd0;
  localparam logic [STEP_W-1:0] STEP_TOE1  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_HEEL2 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_TOE2  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DONE  = 3'd4;

  // Division of a 12-bit swing by 100 as a multiply by 2^22/100, rounded up.
  // The error stays below 0.001 for every 12-bit swing, so the floor is exact.
  localparam int RECIP_W      = 16;
  localparam int PROD_W       = DATA_W + RECIP_W;
  localparam int MARGIN_SHIFT = 22;
  localparam int MARGIN_W     = PROD_W - MARGIN_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_SORT,
    ST_TRIM,
    ST_PUSH
  } state_t;

  // Input beat.
  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              restart;
  } in_t;

  // Output beat.
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              window_stable;
    logic              finished;
    logic              range_ok;
    logic [DATA_W-1:0] range_low;
    logic [DATA_W-1:0] range_high;
  } out_t;

  // Status from the window scan unit.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } scan_res_t;

endpackage

// File: design/pedal_range_calibrator_unit.sv
// ----------------------------------------------------------------------------
// Pedal range calibrator
// Tracks pedal stability over a window of recent ADC codes and walks the
// heel, toe, heel, toe steps, then reports the trimmed calibrated range.
//
//   Channel  Direction  Handshake          Payload
//   in       to block   in_valid/in_stall  in_data  (sample, restart)
//   out      from block out_valid/out_stall out_data (step, flags, range)
//   cfg      to block   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A sample that fills the window runs the one-entry-per-cycle min/max scan
// over the window memory; completing the last step adds the sort and trim
// states. Restarts, samples before the window is full and samples after
// completion skip the scan and go straight to the push state.
// Reset is synchronous and clears the sequencer and calibration progress.
// A stalled output holds its beat; the next input beat is still taken
// while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module pedal_range_calibrator_unit #(
  parameter int WINDOW_LEN = prc_pkg::WINDOW_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  prc_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output prc_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prc_pkg::DATA_W-1:0]     cfg_data
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int DW     = prc_pkg::DATA_W;

  prc_pkg::state_t state;
  prc_pkg::state_t state_next;

  // Configuration registers.
  logic [DW-1:0]               threshold;
  logic [prc_pkg::TICKS_W-1:0] ticks_needed;
  logic [DW-1:0]               min_swing;

  // Calibration progress.
  logic [SLOT_W-1:0]           write_slot;
  logic [FILL_W-1:0]           fill_count;
  logic [prc_pkg::TICKS_W-1:0] stable_run;
  logic [prc_pkg::STEP_W-1:0]  current_step;

  // Working values.
  logic [DW-1:0]               cur_sample;
  logic [DW-1:0]               tracked_min;
  logic [DW-1:0]               tracked_max;
  logic [DW-1:0]               swing;
  logic [prc_pkg::PROD_W-1:0]  prod;
  logic                        res_stable;
  logic                        res_finished;
  logic                        res_ok;
  logic [DW-1:0]               res_low;
  logic [DW-1:0]               res_high;

  prc_pkg::scan_res_t          scan_res;

  logic                        accept;
  logic                        skip_item;
  logic [FILL_W-1:0]           fill_inc;
  logic                        window_full;
  logic [DW-1:0]               span;
  logic                        win_stable;
  logic [prc_pkg::TICKS_W-1:0] run_inc;
  logic                        step_end;
  logic                        swap;
  logic [DW-1:0]               sort_lo;
  logic [DW-1:0]               sort_hi;
  logic [DW-1:0]               sort_swing;
  logic [prc_pkg::MARGIN_W-1:0] margin;
  logic [DW:0]                 fmin;
  logic [DW:0]                 fmax;
  logic                        trim_ok;
  logic                        push_go;

  assign in_stall  = (state != prc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign push_go   = !out_valid || !out_stall;

  // Item classification on the accepting cycle.
  assign skip_item   = in_data.restart || (current_step == prc_pkg::STEP_DONE);
  assign fill_inc    = (fill_count == FILL_W'(WINDOW_LEN)) ? fill_count
                                                         : fill_count + FILL_W'(1);
  assign window_full = (fill_inc == FILL_W'(WINDOW_LEN));

  // Stability decision from the scan result.
  assign span       = scan_res.hi - scan_res.lo;
  assign win_stable = (span < threshold);
  assign run_inc    = stable_run + prc_pkg::TICKS_W'(1);
  assign step_end   = win_stable && (run_inc >= ticks_needed);

  // Ordering of the tracked extremes.
  assign swap       = (tracked_min > tracked_max);
  assign sort_lo    = swap ? tracked_max : tracked_min;
  assign sort_hi    = swap ? tracked_min : tracked_max;
  assign sort_swing = sort_hi - sort_lo;

  // One percent trim.
  assign margin  = prod[prc_pkg::PROD_W-1:prc_pkg::MARGIN_SHIFT];
  assign fmin    = {1'b0, tracked_min} + (DW+1)'(margin);
  assign fmax    = {1'b0, tracked_max} - (DW+1)'(margin);
  assign trim_ok = (fmin < fmax) && (swing > min_swing);

  prc_window_scan #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept && !skip_item),
    .wr_addr(write_slot),
    .wr_data(in_data.sample),
    .start  (accept && !skip_item && window_full),
    .res    (scan_res)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      prc_pkg::ST_IDLE: begin
        if (accept) begin
          if (!skip_item && window_full) begin
            state_next = prc_pkg::ST_SCAN;
          end else begin
            state_next = prc_pkg::ST_PUSH;
          end
        end
      end
      prc_pkg::ST_SCAN: begin
        if (scan_res.done) begin
          state_next = prc_pkg::ST_EVAL;
        end
      end
      prc_pkg::ST_EVAL: begin
        if (step_end && (current_step == prc_pkg::STEP_TOE2)) begin
          state_next = prc_pkg::ST_SORT;
        end else begin
          state_next = prc_pkg::ST_PUSH;
        end
      end
      prc_pkg::ST_SORT: state_next = prc_pkg::ST_TRIM;
      prc_pkg::ST_TRIM: state_next = prc_pkg::ST_PUSH;
      prc_pkg::ST_PUSH: begin
        if (push_go) begin
          state_next = prc_pkg::ST_IDLE;
        end
      end
      default: state_next = prc_pkg::ST_IDLE;
    endcase
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= prc_pkg::THRESHOLD_RST;
      ticks_needed <= prc_pkg::TICKS_RST;
      min_swing    <= prc_pkg::MIN_SWING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        prc_pkg::CFG_THRESHOLD: threshold    <= cfg_data;
        prc_pkg::CFG_TICKS:     ticks_needed <= cfg_data[prc_pkg::TICKS_W-1:0];
        prc_pkg::CFG_MIN_SWING: min_swing    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Calibration progress and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      fill_count   <= '0;
      stable_run   <= '0;
      current_step <= prc_pkg::STEP_HEEL1;
      out_valid    <= 1'b0;
    end else begin
      // The push state reloads the output register itself.
      if (out_valid && !out_stall && (state != prc_pkg::ST_PUSH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        prc_pkg::ST_IDLE: begin
          if (accept) begin
            if (in_data.restart) begin
              write_slot   <= '0;
              fill_count   <= '0;
              stable_run   <= '0;
              current_step <= prc_pkg::STEP_HEEL1;
            end else if (current_step != prc_pkg::STEP_DONE) begin
              write_slot <= (write_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0
                                                                 : write_slot + SLOT_W'(1);
              fill_count <= fill_inc;
              if (!window_full) begin
                stable_run <= '0;
              end
            end
          end
        end
        prc_pkg::ST_EVAL: begin
          if (!win_stable) begin
            stable_run <= '0;
          end else if (step_end) begin
            stable_run   <= '0;
            fill_count   <= '0;
            write_slot   <= '0;
            current_step <= current_step + prc_pkg::STEP_W'(1);
          end else begin
            stable_run <= run_inc;
          end
        end
        prc_pkg::ST_PUSH: begin
          if (push_go) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields, tracked extremes and the trim product.
  always_ff @(posedge clk) begin
    unique case (state)
      prc_pkg::ST_IDLE: begin
        if (accept) begin
          cur_sample   <= in_data.sample;
          res_stable   <= 1'b0;
          res_finished <= 1'b0;
          res_ok       <= 1'b0;
          res_low      <= '0;
          res_high     <= '0;
        end
      end
      prc_pkg::ST_EVAL: begin
        res_stable <= win_stable;
        if (step_end) begin
          unique case (current_step)
            prc_pkg::STEP_HEEL1: tracked_min <= cur_sample;
            prc_pkg::STEP_HEEL2: begin
              if (cur_sample < tracked_min) begin
                tracked_min <= cur_sample;
              end
            end
            prc_pkg::STEP_TOE1: tracked_max <= cur_sample;
            prc_pkg::STEP_TOE2: begin
              if (cur_sample > tracked_max) begin
                tracked_max <= cur_sample;
              end
            end
            default: ;
          endcase
        end
      end
      prc_pkg::ST_SORT: begin
        tracked_min <= sort_lo;
        tracked_max <= sort_hi;
        swing       <= sort_swing;
        prod        <= prc_pkg::PROD_W'(sort_swing) * prc_pkg::PROD_W'(prc_pkg::RECIP_100);
      end
      prc_pkg::ST_TRIM: begin
        res_finished <= 1'b1;
        res_ok       <= trim_ok;
        if (trim_ok) begin
          res_low  <= fmin[DW-1:0];
          res_high <= fmax[DW-1:0];
        end
      end
      prc_pkg::ST_PUSH: begin
        if (push_go) begin
          out_data.step          <= current_step;
          out_data.window_stable <= res_stable;
          out_data.finished      <= res_finished;
          out_data.range_ok      <= res_ok;
          out_data.range_low     <= res_low;
          out_data.range_high    <= res_high;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // A finished beat always reports the completed step.
  a_finished_step: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.finished || (out_data.step == prc_pkg::STEP_DONE)))
    else $error("finished beat without completed step");

  // A good range is only reported on completion and is properly ordered.
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.range_ok) |->
      (out_data.finished && (out_data.range_low < out_data.range_high)))
    else $error("range_ok beat with bad ordering or not finished");

  // The fill count never passes the window length.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW_LEN))
    else $error("fill count past window length");

  // The scan unit only completes while the sequencer waits for it.
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    scan_res.done |-> (state == prc_pkg::ST_SCAN))
    else $error("scan done outside scan state");
`endif

endmodule

// File: design/prc_window_scan.sv
// ----------------------------------------------------------------------------
// Window store and min/max scan
// Holds the sample ring and, on start, walks every entry through one
// shared min/max compare, one entry per cycle, then flags done.
// ----------------------------------------------------------------------------
module prc_window_scan #(
  parameter int WINDOW_LEN = prc_pkg::WINDOW_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [$clog2(WINDOW_LEN)-1:0]   wr_addr,
  input  logic [prc_pkg::DATA_W-1:0]      wr_data,
  input  logic                            start,
  output prc_pkg::scan_res_t              res
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);

  logic [prc_pkg::DATA_W-1:0] mem [WINDOW_LEN];
  logic [prc_pkg::DATA_W-1:0] rd_data;
  logic [prc_pkg::DATA_W-1:0] lo;
  logic [prc_pkg::DATA_W-1:0] hi;
  logic [CNT_W-1:0]           cnt;
  logic                       active;
  logic                       done;
  logic                       rd_en;
  logic                       last;

  assign last  = (cnt == CNT_W'(WINDOW_LEN));
  assign rd_en = active && !last;

  // Sample memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[cnt[SLOT_W-1:0]];
    end
  end

  // Scan counter: one read issued per cycle; done rises together with the last fold.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= !start && active && last;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + CNT_W'(1);
        if (last) begin
          active <= 1'b0;
        end
      end
    end
  end

  // Shared min/max compare, folding the entry read on the previous cycle.
  always_ff @(posedge clk) begin
    if (active && (cnt != '0)) begin
      if (cnt == CNT_W'(1)) begin
        lo <= rd_data;
        hi <= rd_data;
      end else begin
        if (rd_data < lo) begin
          lo <= rd_data;
        end
        if (rd_data > hi) begin
          hi <= rd_data;
        end
      end
    end
  end

  assign res.done = done;
  assign res.lo   = lo;
  assign res.hi   = hi;

endmodule
